// File: rtl/core/dbc_pkg.sv
// Shared types and constants for the button debounce press classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package dbc_pkg;

  localparam int HIST_W     = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int DUR_W      = 32;
  localparam int PCOUNT_W   = 8;

  localparam logic [HIST_W-1:0] PRESS_PATTERN   = 16'h3FFF;
  localparam logic [HIST_W-1:0] RELEASE_PATTERN = 16'hFFC0;

  typedef enum logic [1:0] {
    MODE_HOLD     = 2'd0,
    MODE_DURATION = 2'd1,
    MODE_COUNT    = 2'd2
  } dbc_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE            = 3'd0,
    REG_SAMPLE_INTERVAL = 3'd1,
    REG_HOLD_TICKS      = 3'd2,
    REG_TIMEOUT_TICKS   = 3'd3,
    REG_WINDOW_TICKS    = 3'd4
  } dbc_reg_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CFG_W-1:0] sample_interval;
    logic [CFG_W-1:0] hold_ticks;
    logic [CFG_W-1:0] timeout_ticks;
    logic [CFG_W-1:0] window_ticks;
  } dbc_cfg_t;

  // Debounce events for the current tick
  typedef struct packed {
    logic sampled;
    logic press;
    logic release_evt;
  } dbc_evt_t;

  typedef struct packed {
    logic                hold_detected;
    logic                duration_valid;
    logic [DUR_W-1:0]    duration;
    logic                count_valid;
    logic [PCOUNT_W-1:0] press_count;
  } dbc_res_t;

endpackage

`default_nettype wire

// File: rtl/core/dbc_sampler.sv
// Sample gap counter and 16-bit debounce history with press/release match.
// Depends on dbc_pkg.
`default_nettype none

module dbc_sampler (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire logic                     pin_level,
  input  wire logic [dbc_pkg::CFG_W-1:0] sample_interval,
  output dbc_pkg::dbc_evt_t             evt
);
  import dbc_pkg::*;

  logic [CFG_W-1:0]  sample_gap_r, sample_gap_nxt, gap_inc;
  logic [HIST_W-1:0] history_r, history_nxt;
  logic              take;

  always_comb begin
    gap_inc        = (sample_gap_r == '1) ? sample_gap_r : sample_gap_r + 1'b1;
    take           = (gap_inc >= sample_interval);
    sample_gap_nxt = take ? '0 : gap_inc;
    history_nxt    = take ? {history_r[HIST_W-2:0], pin_level} : history_r;
    evt.sampled     = take;
    evt.press       = take && (history_nxt == PRESS_PATTERN);
    evt.release_evt = take && (history_nxt == RELEASE_PATTERN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_gap_r <= '0;
      history_r    <= '0;
    end else if (step) begin
      sample_gap_r <= sample_gap_nxt;
      history_r    <= history_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dbc_classifier.sv
// Mode logic on the shared saturating tick timer: hold detect, press
// duration and windowed release count. Depends on dbc_pkg.
`default_nettype none

module dbc_classifier #(
  parameter int TIMER_BITS = 32,
  parameter int COUNT_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              pin_level,
  input  dbc_pkg::dbc_cfg_t      cfg,
  input  dbc_pkg::dbc_evt_t      evt,
  output dbc_pkg::dbc_res_t      res
);
  import dbc_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int CNT_W = (COUNT_BITS > PCOUNT_W) ? COUNT_BITS : PCOUNT_W;

  logic                  running_r, running_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [CMP_W-1:0]      el_ext;
  logic [CNT_W-1:0]      cnt_ext;

  always_comb begin
    running_nxt = running_r;
    elapsed_nxt = elapsed_r;
    count_nxt   = count_r;
    res         = '0;

    if (running_r && (elapsed_r != '1))
      elapsed_nxt = elapsed_r + 1'b1;

    unique case (dbc_mode_t'(cfg.mode))
      MODE_HOLD: begin
        if (evt.press && !running_nxt) begin
          running_nxt = 1'b1;
          elapsed_nxt = '0;
        end
      end
      MODE_DURATION: begin
        if (evt.press && !running_nxt) begin
          running_nxt = 1'b1;
          elapsed_nxt = '0;
        end
      end
      MODE_COUNT: begin
        if (evt.release_evt) begin
          if (!running_nxt) begin
            running_nxt = 1'b1;
            elapsed_nxt = '0;
          end
          if (count_nxt != '1)
            count_nxt = count_nxt + 1'b1;
        end
      end
      default: ;
    endcase

    el_ext  = CMP_W'(elapsed_nxt);
    cnt_ext = CNT_W'(count_nxt);

    unique case (dbc_mode_t'(cfg.mode))
      MODE_HOLD: begin
        if (running_nxt && ((pin_level && el_ext >= CMP_W'(cfg.hold_ticks)) ||
                            el_ext >= CMP_W'(cfg.timeout_ticks))) begin
          res.hold_detected = 1'b1;
          running_nxt       = 1'b0;
        end
      end
      MODE_DURATION: begin
        if (running_nxt && (el_ext >= CMP_W'(cfg.timeout_ticks) || !pin_level)) begin
          res.duration_valid = 1'b1;
          res.duration       = (el_ext > CMP_W'({DUR_W{1'b1}})) ? '1 : el_ext[DUR_W-1:0];
          running_nxt        = 1'b0;
          elapsed_nxt        = '0;
        end
      end
      MODE_COUNT: begin
        if (running_nxt && el_ext >= CMP_W'(cfg.window_ticks)) begin
          res.count_valid = 1'b1;
          res.press_count = (cnt_ext > CNT_W'({PCOUNT_W{1'b1}})) ? '1
                                                               : cnt_ext[PCOUNT_W-1:0];
          count_nxt       = '0;
          running_nxt     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      elapsed_r <= '0;
      count_r   <= '0;
    end else if (step) begin
      running_r <= running_nxt;
      elapsed_r <= elapsed_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/button_debounce_press_classifier.sv
// Top level of the button debounce press classifier: input and result
// registers, configuration registers. Depends on dbc_pkg, dbc_sampler,
// dbc_classifier.
//
// Each input transfer is one tick of the raw button level. A sample is shifted
// into a 16-bit history every sample_interval ticks; 0x3FFF flags a press and
// 0xFFC0 a release. The mode register picks hold detect, press duration or
// release count in a window, all on one saturating timer. Exactly one result
// transfer follows each input transfer. Throughput is one tick per clock while
// the output does not stall; a tick passes through the input register, then the
// result register written by the single combinational pass over the sampler and
// the timer logic. Either side may stall at any time. Configuration writes are
// always ready and must only be issued while no tick is in flight.
`default_nettype none

module button_debounce_press_classifier #(
  parameter int TIMER_BITS = 32,
  parameter int COUNT_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_pin_level,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_sampled,
  output logic                               out_press_edge,
  output logic                               out_release_edge,
  output logic                               out_hold_detected,
  output logic                               out_duration_valid,
  output logic [dbc_pkg::DUR_W-1:0]          out_duration,
  output logic                               out_count_valid,
  output logic [dbc_pkg::PCOUNT_W-1:0]       out_press_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dbc_pkg::CFG_W-1:0]     cfg_data
);
  import dbc_pkg::*;

  dbc_cfg_t cfg_r;
  logic     in_valid_r, pin_r;
  logic     out_valid_r;
  logic     advance, step;
  dbc_evt_t evt, evt_r;
  dbc_res_t res, res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode            <= MODE_HOLD;
      cfg_r.sample_interval <= 32'd5;
      cfg_r.hold_ticks      <= 32'd1000;
      cfg_r.timeout_ticks   <= 32'd3000;
      cfg_r.window_ticks    <= 32'd500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dbc_reg_t'(cfg_index))
        REG_MODE:            cfg_r.mode            <= cfg_data[1:0];
        REG_SAMPLE_INTERVAL: cfg_r.sample_interval <= cfg_data;
        REG_HOLD_TICKS:      cfg_r.hold_ticks      <= cfg_data;
        REG_TIMEOUT_TICKS:   cfg_r.timeout_ticks   <= cfg_data;
        REG_WINDOW_TICKS:    cfg_r.window_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register empties or drains this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign step     = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall)
      pin_r <= in_pin_level;
  end

  dbc_sampler u_sampler (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .pin_level       (pin_r),
    .sample_interval (cfg_r.sample_interval),
    .evt             (evt)
  );

  dbc_classifier #(
    .TIMER_BITS (TIMER_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_classifier (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .pin_level (pin_r),
    .cfg       (cfg_r),
    .evt       (evt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      evt_r <= evt;
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sampled        = evt_r.sampled;
  assign out_press_edge     = evt_r.press;
  assign out_release_edge   = evt_r.release_evt;
  assign out_hold_detected  = res_r.hold_detected;
  assign out_duration_valid = res_r.duration_valid;
  assign out_duration       = res_r.duration;
  assign out_count_valid    = res_r.count_valid;
  assign out_press_count    = res_r.press_count;

endmodule

`default_nettype wire
